@@ hw/rtl/rau_pkg.sv @@
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int PW    = 64;   // product width
    localparam int CNTW  = 7;    // bit counter for 64-step divider

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MAG, S_GCD_START, S_GCD_WAIT,
        S_DIVN_START, S_DIVN_WAIT, S_DIVD_START, S_DIVD_WAIT, S_CHECK, S_DONE
    } state_t;

    // divider operand select: gcd x%y, num/g, den/g
    typedef enum logic [1:0] {
        DSEL_GCD = 2'd0,
        DSEL_NUM = 2'd1,
        DSEL_DEN = 2'd2
    } div_sel_t;

    // datapath commands
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mag;
        logic gcd_step;      // one remainder update (after divider result)
        logic div_start;
        div_sel_t div_sel;
        logic take_q;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic bad;       // zero den or divide by zero
        logic zero_num;
        logic y_zero;
        logic div_done;
    } sts_t;

endpackage

@@ hw/rtl/rau_div.sv @@
module rau_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [rau_pkg::PW-1:0] dividend,
    input  logic [rau_pkg::PW-1:0] divisor,
    output logic                  done,
    output logic [rau_pkg::PW-1:0] quot,
    output logic [rau_pkg::PW-1:0] rem
);
    import rau_pkg::*;

    logic [PW-1:0]   q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next, done_reg, done_next;
    logic [PW:0]     sh;

    // restoring divider, one bit per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        sh        = {r_reg, q_reg[PW-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CNTW'(PW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_next = PW'(sh - {1'b0, d_reg});
                q_next = {q_reg[PW-2:0], 1'b1};
            end
            else
            begin
                r_next = sh[PW-1:0];
                q_next = {q_reg[PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

@@ hw/rtl/rau_datapath.sv @@
module rau_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::in_beat_t in_beat,
    input  rau_pkg::cmd_t     cmd,
    input  rau_pkg::status_t  st_code,
    output rau_pkg::sts_t     sts,
    output rau_pkg::out_beat_t out_beat,
    output logic              fits
);
    import rau_pkg::*;

    in_beat_t in_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, n_reg, n_next;
    logic signed [PW-1:0] prod1, prod2;
    logic [PW-1:0] d_reg, d_next;
    logic [PW-1:0] un_reg, ud_reg, x_reg, y_reg;
    logic          neg_reg;
    logic signed [31:0] held_num_reg;
    logic [30:0]        held_den_reg;
    logic signed [32:0] m1a, m1b, m2a, m2b;
    logic [PW-1:0] dvd, dvs, quot, rem;
    logic          div_done;
    logic [PW-1:0] lim;

    // operand selection for the two multiplies
    always_comb
    begin
        m1a = 33'(in_reg.a_num);
        m2a = 33'(in_reg.a_num);
        m1b = $signed({2'b00, in_reg.b_den});
        m2b = $signed({2'b00, in_reg.a_den});
        if (in_reg.op == OP_MUL)
        begin
            m1b = 33'(in_reg.b_num);
        end
        if (in_reg.op == OP_ADD || in_reg.op == OP_SUB)
        begin
            m2a = 33'(in_reg.b_num);
        end
        if (in_reg.op == OP_MUL)
        begin
            m2a = $signed({2'b00, in_reg.b_den});
        end
        if (in_reg.op == OP_DIV)
        begin
            m2a = 33'(in_reg.b_num);
        end
    end

    // full-width signed products
    assign prod1 = m1a * m1b;
    assign prod2 = m2a * m2b;

    // combine products into n and d
    always_comb
    begin
        n_next = n_reg;
        d_next = d_reg;
        unique case (op_t'(in_reg.op))
            OP_ADD: begin n_next = p1_reg + p2_reg; d_next = {2'b00, in_reg.a_den} * in_reg.b_den; end
            OP_SUB: begin n_next = p1_reg - p2_reg; d_next = {2'b00, in_reg.a_den} * in_reg.b_den; end
            OP_MUL: begin n_next = p1_reg; d_next = p2_reg; end
            OP_DIV: begin n_next = p1_reg; d_next = p2_reg; end
            default: ;
        endcase
    end

    // divider operand mux
    always_comb
    begin
        unique case (cmd.div_sel)
            DSEL_GCD: begin dvd = x_reg;  dvs = y_reg; end
            DSEL_NUM: begin dvd = un_reg; dvs = x_reg; end
            default:  begin dvd = ud_reg; dvs = x_reg; end
        endcase
    end

    rau_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(dvd), .divisor(dvs), .done(div_done), .quot(quot), .rem(rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_beat;
        if (cmd.mul1)
        begin
            p1_reg <= prod1;
            p2_reg <= prod2;
        end
        if (cmd.mul2)
        begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
        if (cmd.mag)
        begin
            neg_reg <= n_reg[PW-1] ^ d_reg[PW-1];
            un_reg  <= n_reg[PW-1] ? PW'(-n_reg) : n_reg;
            ud_reg  <= d_reg[PW-1] ? PW'(-$signed(d_reg)) : d_reg;
            x_reg   <= n_reg[PW-1] ? PW'(-n_reg) : n_reg;
            y_reg   <= d_reg[PW-1] ? PW'(-$signed(d_reg)) : d_reg;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= rem;
        end
        if (cmd.take_q)
        begin
            if (cmd.div_sel == DSEL_NUM)
                un_reg <= quot;
            else
                ud_reg <= quot;
        end
        if (cmd.commit && sts.zero_num)
        begin
            neg_reg <= 1'b0;
            un_reg  <= '0;
            ud_reg  <= PW'(1);
        end
    end

    // held result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_num_reg <= '0;
            held_den_reg <= 31'd1;
        end
        else if (cmd.commit && fits && st_code == ST_OK)
        begin
            held_num_reg <= sts.zero_num ? 32'sd0 :
                            (neg_reg ? 32'(-un_reg) : un_reg[31:0]);
            held_den_reg <= sts.zero_num ? 31'd1 : ud_reg[30:0];
        end
    end

    assign lim = PW'(1) << (WIDTH - 1);
    assign fits = sts.zero_num ||
                  ((neg_reg ? un_reg <= lim : un_reg < lim) && ud_reg < lim);

    assign sts.bad = (in_reg.a_den == '0) || (in_reg.b_den == '0) ||
                     (in_reg.op == OP_DIV && in_reg.b_num == '0);
    assign sts.zero_num = (un_reg == '0);
    assign sts.y_zero   = (y_reg == '0);
    assign sts.div_done = div_done;

    assign out_beat.res_num = held_num_reg;
    assign out_beat.res_den = held_den_reg;
    assign out_beat.status  = st_code;
endmodule

@@ hw/rtl/rau_ctrl.sv @@
module rau_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rau_pkg::sts_t    sts,
    input  logic             fits,
    output rau_pkg::cmd_t    cmd,
    output rau_pkg::status_t st_code,
    output logic             busy,
    output logic             strobe
);
    import rau_pkg::*;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        strobe     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (sts.bad)
                begin
                    code_next  = ST_DIVZ;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul1   = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin cmd.mul2 = 1'b1; state_next = S_MAG; end
            S_MAG:  begin cmd.mag = 1'b1; state_next = S_GCD_START; end
            S_GCD_START:
            begin
                if (sts.zero_num)
                    state_next = S_CHECK;
                else if (sts.y_zero)
                    state_next = S_DIVN_START;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = S_GCD_START;
                end
            end
            S_DIVN_START:
            begin
                cmd.div_sel   = DSEL_NUM;
                cmd.div_start = 1'b1;
                state_next    = S_DIVN_WAIT;
            end
            S_DIVN_WAIT:
            begin
                cmd.div_sel = DSEL_NUM;
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_DIVD_START;
                end
            end
            S_DIVD_START:
            begin
                cmd.div_sel   = DSEL_DEN;
                cmd.div_start = 1'b1;
                state_next    = S_DIVD_WAIT;
            end
            S_DIVD_WAIT:
            begin
                cmd.div_sel = DSEL_DEN;
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                code_next  = fits ? ST_OK : ST_OVF;
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                strobe     = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CHECK)
            cmd.commit = 1'b1;
    end

    assign st_code = (state_reg == S_CHECK) ? (fits ? ST_OK : ST_OVF) : code_reg;
    assign busy    = (state_reg != S_IDLE);
endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// channel  | ports                 | handshake
// command  | start, busy, cmd_beat | taken when start & !busy
// result   | strobe, res_beat      | one-cycle strobe, no back-pressure
//
// one operation at a time; the divisions run on the shared 64-bit divider
// (start, 64 bit steps, done) and are the gcd steps plus two exact divisions.
// a zero result skips the divisions; invalid operands go straight to the
// strobe with no arithmetic.
// reset clears the held result to 0/1.
// the receiver cannot stall; res_beat is valid while strobe is high.
module rational_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rau_pkg::in_beat_t  cmd_beat,
    output logic               busy,
    output logic               strobe,
    output rau_pkg::out_beat_t res_beat
);
    import rau_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    status_t st_code;
    logic    fits;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .fits(fits),
        .cmd(cmd), .st_code(st_code), .busy(busy), .strobe(strobe)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_beat(cmd_beat), .cmd(cmd),
        .st_code(st_code), .sts(sts), .out_beat(res_beat), .fits(fits)
    );

    // checks
    a_no_start_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe) else $error("strobe right after accept");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");
    a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !busy) else $error("busy after strobe");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> res_beat.res_den != '0) else $error("zero denominator held");
endmodule
